// ----- rtl/rtc_pkg.sv -----
// Shared types and constants for the RGB to CMYK channel mask core.
`timescale 1ns / 1ps
package rtc_pkg;

  localparam int          LANES         = 3;
  localparam int          DIV_STAGES    = 4;
  localparam logic [7:0]  FULL_SCALE    = 8'd255;
  localparam logic [7:0]  THR_RESET     = 8'd64;
  localparam logic [15:0] THR_SCALE     = 16'd65025;
  localparam logic [23:0] THR_SCALED_RESET = 24'(32'(THR_RESET) * 32'(THR_SCALE));

  localparam int LANE_CYAN    = 0;
  localparam int LANE_MAGENTA = 1;
  localparam int LANE_YELLOW  = 2;

  typedef struct packed {
    logic [LANES-1:0][7:0] rem;
    logic [LANES-1:0][7:0] low;
    logic [LANES-1:0][7:0] quo;
    logic [7:0]            dvs;
    logic [7:0]            black;
    logic                  zero;
  } div_t;

  typedef struct packed {
    logic [7:0] cyan;
    logic [7:0] magenta;
    logic [7:0] yellow;
    logic [7:0] black;
    logic       mask_cyan;
    logic       mask_magenta;
    logic       mask_yellow;
    logic       mask_black;
  } res_t;

endpackage

// ----- rtl/rtc_front.sv -----
// Input register, channel maximum and divider numerators.
`timescale 1ns / 1ps
module rtc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    red,
  input  logic [7:0]    green,
  input  logic [7:0]    blue,
  output logic          out_valid,
  output rtc_pkg::div_t out_data
);
  import rtc_pkg::*;

  logic       s0_valid;
  logic [7:0] s0_red;
  logic [7:0] s0_green;
  logic [7:0] s0_blue;
  logic [7:0] mx;
  logic [LANES-1:0][7:0] chan;
  div_t       div_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= in_valid;
    end
    s0_red   <= red;
    s0_green <= green;
    s0_blue  <= blue;
  end

  always_comb begin
    logic [7:0]  a;
    logic [7:0]  diff;
    logic [15:0] num;
    a  = (s0_red > s0_green) ? s0_red : s0_green;
    mx = (a > s0_blue) ? a : s0_blue;
    chan[LANE_CYAN]    = s0_red;
    chan[LANE_MAGENTA] = s0_green;
    chan[LANE_YELLOW]  = s0_blue;
    div_next = '0;
    for (int i = 0; i < LANES; i++) begin
      diff = mx - chan[i];
      num  = {diff, 8'd0} - {8'd0, diff};
      div_next.rem[i] = num[15:8];
      div_next.low[i] = num[7:0];
      div_next.quo[i] = 8'd0;
    end
    div_next.dvs   = mx;
    div_next.black = FULL_SCALE - mx;
    div_next.zero  = (mx == 8'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s0_valid;
    end
    out_data <= div_next;
  end

endmodule

// ----- rtl/rtc_div_stage.sv -----
// One registered stage of the three-lane restoring divider, two quotient bits.
`timescale 1ns / 1ps
module rtc_div_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  rtc_pkg::div_t in_data,
  output logic          out_valid,
  output rtc_pkg::div_t out_data
);
  import rtc_pkg::*;

  div_t div_next;

  always_comb begin
    logic [8:0] t;
    div_next = in_data;
    for (int i = 0; i < LANES; i++) begin
      for (int s = 0; s < 2; s++) begin
        t = {div_next.rem[i], div_next.low[i][7]};
        div_next.low[i] = {div_next.low[i][6:0], 1'b0};
        if (t >= {1'b0, in_data.dvs}) begin
          t = t - {1'b0, in_data.dvs};
          div_next.quo[i] = {div_next.quo[i][6:0], 1'b1};
        end else begin
          div_next.quo[i] = {div_next.quo[i][6:0], 1'b0};
        end
        div_next.rem[i] = t[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_data <= div_next;
  end

endmodule

// ----- rtl/rtc_mask.sv -----
// Channel products and threshold compare, two stages, with the output register.
`timescale 1ns / 1ps
module rtc_mask (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  rtc_pkg::div_t in_data,
  input  logic [23:0]   thr_scaled,
  output logic          out_valid,
  output rtc_pkg::res_t out_data
);
  import rtc_pkg::*;

  logic             p_valid;
  logic [3:0][7:0]  p_code;
  logic [3:0][15:0] p_prod;
  logic             p_zero;
  logic [3:0][7:0]  code;
  logic [3:0][15:0] prod_next;
  logic [3:0]       over;
  res_t             res_next;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      code[i] = in_data.zero ? 8'd0 : in_data.quo[i];
    end
    code[3] = in_data.black;
    for (int i = 0; i < 4; i++) begin
      prod_next[i] = 16'(code[i]) * 16'(FULL_SCALE - code[(i + 1) % 4]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= in_valid;
    end
    p_code <= code;
    p_prod <= prod_next;
    p_zero <= in_data.zero;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      over[i] = !p_zero && ({p_prod[i], 8'd0} > thr_scaled);
    end
    res_next.cyan         = p_code[0];
    res_next.magenta      = p_code[1];
    res_next.yellow       = p_code[2];
    res_next.black        = p_code[3];
    res_next.mask_cyan    = over[0];
    res_next.mask_magenta = over[1];
    res_next.mask_yellow  = over[2];
    res_next.mask_black   = over[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= p_valid;
    end
    out_data <= res_next;
  end

endmodule

// ----- rtl/rgb_to_cmyk_channel_masks_core.sv -----
// Top level of the RGB to CMYK converter with channel product masks.
//
// Usage:
//   An item (red, green, blue) is taken at a rising edge with start high
//   and busy low. busy is low except during reset, so one item may enter
//   every cycle.
//   The result (cyan, magenta, yellow, black and four mask bits) shows for
//   one cycle with done high. done rises once the item has passed the front,
//   divider and mask registers; items come out in order, one result per
//   item.
//   Throughput: one item per cycle. Latency is set by two front stages,
//   a four-stage divider (two quotient bits per stage, one lane per
//   channel), a product stage and the compare/output stage.
//   The receiver cannot stall; results are not held.
//   Configuration: cfg_data is the mask threshold (Q0.8), written when
//   cfg_valid and cfg_ready are high. Write it only with no items in flight.
//   Reset (rst, synchronous) drops all items in flight and sets the
//   threshold back to 64.
`timescale 1ns / 1ps
module rgb_to_cmyk_channel_masks_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output logic       done,
  output logic [7:0] cyan,
  output logic [7:0] magenta,
  output logic [7:0] yellow,
  output logic [7:0] black,
  output logic       mask_cyan,
  output logic       mask_magenta,
  output logic       mask_yellow,
  output logic       mask_black
);
  import rtc_pkg::*;

  logic [23:0] thr_scaled;
  logic        front_valid;
  div_t        front_data;
  logic [DIV_STAGES:0] dv_valid;
  div_t        dv_data [DIV_STAGES+1];
  res_t        res;

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_scaled <= THR_SCALED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_scaled <= {16'd0, cfg_data} * {8'd0, THR_SCALE};
    end
  end

  rtc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (front_valid),
    .out_data  (front_data)
  );

  assign dv_valid[0] = front_valid;
  assign dv_data[0]  = front_data;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    rtc_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv_valid[g]),
      .in_data   (dv_data[g]),
      .out_valid (dv_valid[g+1]),
      .out_data  (dv_data[g+1])
    );
  end

  rtc_mask u_mask (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (dv_valid[DIV_STAGES]),
    .in_data    (dv_data[DIV_STAGES]),
    .thr_scaled (thr_scaled),
    .out_valid  (done),
    .out_data   (res)
  );

  assign cyan         = res.cyan;
  assign magenta      = res.magenta;
  assign yellow       = res.yellow;
  assign black        = res.black;
  assign mask_cyan    = res.mask_cyan;
  assign mask_magenta = res.mask_magenta;
  assign mask_yellow  = res.mask_yellow;
  assign mask_black   = res.mask_black;

endmodule

// ----- rtl/rtc_checker.sv -----
// Port-level checks for the RGB to CMYK core, bound to the top level.
`timescale 1ns / 1ps
module rtc_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic       done,
  input logic [7:0] cyan,
  input logic [7:0] magenta,
  input logic [7:0] yellow,
  input logic [7:0] black,
  input logic       mask_cyan,
  input logic       mask_magenta,
  input logic       mask_yellow,
  input logic       mask_black
);

  logic take;
  assign take = start && !busy;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    take |-> ##8 done)
    else $error("item accepted without a result 8 cycles later");

  a_black_pixel: assert property (@(posedge clk) disable iff (rst)
    (take && red == 8'd0 && green == 8'd0 && blue == 8'd0) |-> ##8
    (black == 8'd255 && cyan == 8'd0 && magenta == 8'd0 && yellow == 8'd0 &&
     !mask_cyan && !mask_magenta && !mask_yellow && !mask_black))
    else $error("black pixel gave a wrong result");

  a_gray_pixel: assert property (@(posedge clk) disable iff (rst)
    (take && red == green && green == blue) |-> ##8
    (cyan == 8'd0 && magenta == 8'd0 && yellow == 8'd0))
    else $error("gray pixel gave nonzero color");

  a_max_channel: assert property (@(posedge clk) disable iff (rst)
    take |-> ##8 (cyan == 8'd0 || magenta == 8'd0 || yellow == 8'd0))
    else $error("no color component is zero");

endmodule

bind rgb_to_cmyk_channel_masks_core rtc_checker u_rtc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .red          (red),
  .green        (green),
  .blue         (blue),
  .done         (done),
  .cyan         (cyan),
  .magenta      (magenta),
  .yellow       (yellow),
  .black        (black),
  .mask_cyan    (mask_cyan),
  .mask_magenta (mask_magenta),
  .mask_yellow  (mask_yellow),
  .mask_black   (mask_black)
);
